// File: rtl/core/dvrt_pkg.sv
// dvrt_pkg: shared types and constants of the distance-vector route table
// request and result structs, mode codes, controller/datapath command types
// no dependencies
package dvrt_pkg;

    localparam logic [2:0]  MODE_VECTOR   = 3'd0;
    localparam logic [2:0]  MODE_TICK     = 3'd1;
    localparam logic [2:0]  MODE_DISABLE  = 3'd2;
    localparam logic [2:0]  MODE_SET_COST = 3'd3;
    localparam logic [2:0]  MODE_READ     = 3'd4;
    localparam logic [2:0]  MODE_LOAD     = 3'd5;

    localparam logic [15:0] INF_COST   = 16'hFFFF;
    localparam logic [1:0]  MISS_LIMIT = 2'd3;
    localparam logic [4:0]  SELF_RESET = 5'd1;

    // read address source
    localparam logic [1:0]  RD_ITEM   = 2'd0;
    localparam logic [1:0]  RD_REPORT = 2'd1;
    localparam logic [1:0]  RD_TICK   = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  peer_id;
        logic [4:0]  dest_id;
        logic [15:0] cost_value;
    } dvrt_in_t;

    typedef struct packed {
        logic [4:0]  entry_id;
        logic [15:0] entry_cost;
        logic [4:0]  entry_next_hop;
        logic        entry_is_neighbor;
        logic        table_changed;
        logic        send_update;
    } dvrt_out_t;

    typedef struct packed {
        logic       load_item;
        logic [1:0] rd_sel;
        logic       exec;
        logic       tick_start;
        logic       tick_step;
        logic       load_out;
    } dvrt_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic tick_done;
        logic out_busy;
    } dvrt_stat_t;

endpackage

// File: rtl/core/dvrt_ctrl.sv
// dvrt_ctrl: sequencing state machine of the route table
// drives datapath commands from request handshake and datapath status
// depends on dvrt_pkg
module dvrt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  dvrt_pkg::dvrt_stat_t stat,
    output dvrt_pkg::dvrt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RPT_RD = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        item_ready     = 1'b0;
        cmd            = '0;
        cmd.rd_sel     = dvrt_pkg::RD_REPORT;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (stat.in_tick)
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_TICK;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                cmd.rd_sel = dvrt_pkg::RD_ITEM;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RPT_RD;
            end
            S_RPT_RD:
            begin
                state_next = S_FIN;
            end
            S_TICK:
            begin
                cmd.rd_sel    = dvrt_pkg::RD_TICK;
                cmd.tick_step = 1'b1;
                if (stat.tick_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/dvrt_datapath.sv
// dvrt_datapath: route and link memories, neighbour flags, relaxation and result register
// executes commands from dvrt_ctrl, one memory read and one write per cycle
// depends on dvrt_pkg
module dvrt_datapath #(
    parameter int NODES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dvrt_pkg::dvrt_in_t   item,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [4:0]           cfg_data,
    output dvrt_pkg::dvrt_out_t  result,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  dvrt_pkg::dvrt_cmd_t  cmd,
    output dvrt_pkg::dvrt_stat_t stat
);

    localparam int IW = $clog2(NODES);
    localparam int XW = (IW > 5) ? IW : 5;

    function automatic logic [IW-1:0] idx_of(input logic [4:0] id);
        logic [XW-1:0] t;
        t = XW'(id) - XW'(1);
        return t[IW-1:0];
    endfunction

    function automatic logic id_ok(input logic [4:0] id);
        return (id != 5'd0) && (32'(id) <= 32'(NODES));
    endfunction

    // memories
    logic [20:0] route_mem [NODES];
    logic [15:0] link_mem  [NODES];

    logic [NODES-1:0] route_vld_reg, route_vld_next;
    logic [NODES-1:0] mark_reg, mark_next;
    logic [NODES-1:0] heard_reg, heard_next;
    logic [1:0]       missed_reg [NODES];
    logic [1:0]       missed_next [NODES];

    dvrt_pkg::dvrt_in_t  item_reg;
    dvrt_pkg::dvrt_out_t out_reg;
    dvrt_pkg::dvrt_out_t res;
    logic                out_valid_reg;
    logic [4:0]          self_id_reg;
    logic                changed_reg, changed_next;
    logic [IW:0]         cnt_reg, cnt_next;
    logic [IW:0]         cnt_m1;
    logic [IW-1:0]       tj;

    logic [20:0]   rd_route_reg;
    logic          rd_vld_reg;
    logic [15:0]   rd_link_reg;
    logic [IW-1:0] raddr;

    logic          r_we;
    logic [IW-1:0] r_waddr;
    logic [20:0]   r_wdata;
    logic          v_clr;
    logic          l_we;

    logic [IW-1:0] pidx, didx, ridx, self_idx;
    logic          self_ok, peer_use, dest_use, rep_ok, rep_self;
    logic [4:0]    rep_id;
    logic [15:0]   eff_cost;
    logic [4:0]    eff_hop;
    logic [16:0]   sum;
    logic [15:0]   sum_sat;
    logic [1:0]    mnew;

    assign pidx     = idx_of(item_reg.peer_id);
    assign didx     = idx_of(item_reg.dest_id);
    assign self_idx = idx_of(self_id_reg);
    assign self_ok  = id_ok(self_id_reg);
    assign peer_use = id_ok(item_reg.peer_id) && (item_reg.peer_id != self_id_reg);
    assign dest_use = id_ok(item_reg.dest_id) && (item_reg.dest_id != self_id_reg);
    assign rep_id   = ((item_reg.mode == dvrt_pkg::MODE_VECTOR) ||
                       (item_reg.mode == dvrt_pkg::MODE_READ)) ?
                      item_reg.dest_id : item_reg.peer_id;
    assign ridx     = idx_of(rep_id);
    assign rep_ok   = id_ok(rep_id);
    assign rep_self = rep_ok && (rep_id == self_id_reg);

    assign eff_cost = rd_vld_reg ? rd_route_reg[20:5] : dvrt_pkg::INF_COST;
    assign eff_hop  = rd_vld_reg ? rd_route_reg[4:0] : 5'd0;
    assign sum      = {1'b0, rd_link_reg} + {1'b0, item_reg.cost_value};
    assign sum_sat  = sum[16] ? dvrt_pkg::INF_COST : sum[15:0];

    assign cnt_m1   = cnt_reg - 1'b1;
    assign tj       = cnt_m1[IW-1:0];

    // read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            dvrt_pkg::RD_ITEM:   raddr = (item_reg.mode == dvrt_pkg::MODE_VECTOR) ? didx : pidx;
            dvrt_pkg::RD_REPORT: raddr = ridx;
            dvrt_pkg::RD_TICK:   raddr = cnt_reg[IW-1:0];
            default:             raddr = ridx;
        endcase
    end

    // update logic
    always_comb
    begin
        route_vld_next = route_vld_reg;
        mark_next      = mark_reg;
        heard_next     = heard_reg;
        missed_next    = missed_reg;
        changed_next   = changed_reg;
        cnt_next       = cnt_reg;
        r_we           = 1'b0;
        r_waddr        = pidx;
        r_wdata        = {item_reg.cost_value, item_reg.peer_id};
        v_clr          = 1'b0;
        l_we           = 1'b0;
        mnew           = 2'd0;

        if (cmd.load_item)
        begin
            changed_next = 1'b0;
        end
        if (cmd.tick_start)
        begin
            cnt_next = '0;
        end

        if (cmd.exec)
        begin
            unique case (item_reg.mode)
                dvrt_pkg::MODE_VECTOR:
                begin
                    if (peer_use && mark_reg[pidx])
                    begin
                        heard_next[pidx]  = 1'b1;
                        missed_next[pidx] = 2'd0;
                        if (dest_use && (sum_sat < eff_cost))
                        begin
                            r_we         = 1'b1;
                            r_waddr      = didx;
                            r_wdata      = {sum_sat, item_reg.peer_id};
                            changed_next = 1'b1;
                        end
                    end
                end
                dvrt_pkg::MODE_DISABLE:
                begin
                    if (peer_use && mark_reg[pidx])
                    begin
                        v_clr             = 1'b1;
                        changed_next      = (eff_cost != dvrt_pkg::INF_COST) ||
                                            (eff_hop != 5'd0);
                        mark_next[pidx]   = 1'b0;
                        heard_next[pidx]  = 1'b0;
                        missed_next[pidx] = 2'd0;
                    end
                end
                dvrt_pkg::MODE_SET_COST:
                begin
                    if (peer_use && mark_reg[pidx])
                    begin
                        l_we         = 1'b1;
                        r_we         = 1'b1;
                        changed_next = (eff_cost != item_reg.cost_value) ||
                                       (eff_hop != item_reg.peer_id);
                    end
                end
                dvrt_pkg::MODE_LOAD:
                begin
                    if (peer_use)
                    begin
                        mark_next[pidx]   = 1'b1;
                        heard_next[pidx]  = 1'b0;
                        missed_next[pidx] = 2'd0;
                        l_we              = 1'b1;
                        r_we              = 1'b1;
                        changed_next      = (eff_cost != item_reg.cost_value) ||
                                            (eff_hop != item_reg.peer_id);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.tick_step)
        begin
            if (!stat.tick_done)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            // entry read in the previous cycle
            if ((cnt_reg != '0) && mark_reg[tj] && heard_reg[tj])
            begin
                mnew = (missed_reg[tj] == dvrt_pkg::MISS_LIMIT) ?
                       dvrt_pkg::MISS_LIMIT : missed_reg[tj] + 2'd1;
                missed_next[tj] = mnew;
                if ((mnew == dvrt_pkg::MISS_LIMIT) && !(self_ok && (self_idx == tj)))
                begin
                    r_we    = 1'b1;
                    r_waddr = tj;
                    r_wdata = {dvrt_pkg::INF_COST, eff_hop};
                    if (eff_cost != dvrt_pkg::INF_COST)
                    begin
                        changed_next = 1'b1;
                    end
                end
            end
        end

        if (r_we)
        begin
            route_vld_next[r_waddr] = 1'b1;
        end
        if (v_clr)
        begin
            route_vld_next[pidx] = 1'b0;
        end
    end

    // result
    always_comb
    begin
        res = '0;
        unique case (item_reg.mode)
            dvrt_pkg::MODE_TICK:
            begin
                res.table_changed = changed_reg;
                res.send_update   = 1'b1;
            end
            dvrt_pkg::MODE_VECTOR, dvrt_pkg::MODE_DISABLE, dvrt_pkg::MODE_SET_COST,
            dvrt_pkg::MODE_READ, dvrt_pkg::MODE_LOAD:
            begin
                res.table_changed = changed_reg;
                if (!rep_ok)
                begin
                    res.entry_cost = dvrt_pkg::INF_COST;
                end
                else if (rep_self)
                begin
                    res.entry_id = rep_id;
                end
                else
                begin
                    res.entry_id          = rep_id;
                    res.entry_cost        = eff_cost;
                    res.entry_next_hop    = eff_hop;
                    res.entry_is_neighbor = mark_reg[ridx];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            route_mem[r_waddr] <= r_wdata;
        end
        if (l_we)
        begin
            link_mem[pidx] <= item_reg.cost_value;
        end
        rd_route_reg <= route_mem[raddr];
        rd_vld_reg   <= route_vld_next[raddr] & route_vld_reg[raddr];
        rd_link_reg  <= link_mem[pidx];
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.load_out)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_vld_reg <= '0;
            mark_reg      <= '0;
            heard_reg     <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                missed_reg[i] <= 2'd0;
            end
            changed_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            self_id_reg   <= dvrt_pkg::SELF_RESET;
        end
        else
        begin
            route_vld_reg <= route_vld_next;
            mark_reg      <= mark_next;
            heard_reg     <= heard_next;
            missed_reg    <= missed_next;
            changed_reg   <= changed_next;
            cnt_reg       <= cnt_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                self_id_reg <= cfg_data;
            end
        end
    end

    assign result         = out_reg;
    assign result_valid   = out_valid_reg;
    assign stat.in_tick   = (item.mode == dvrt_pkg::MODE_TICK);
    assign stat.tick_done = (cnt_reg == (IW+1)'(NODES));
    assign stat.out_busy  = out_valid_reg && !result_ready;

endmodule

// File: rtl/core/distance_vector_route_table_unit.sv
// distance_vector_route_table_unit: top level of the distance-vector route table
// joins dvrt_ctrl and dvrt_datapath; depends on dvrt_pkg
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  item     | item_valid / item_ready    | dvrt_pkg::dvrt_in_t  (one request)
//  result   | result_valid / result_ready| dvrt_pkg::dvrt_out_t (one per request)
//  cfg      | cfg_valid / cfg_ready      | cfg_data, self_id (5 bits)
//
// a non-tick request goes from acceptance to result through one memory read,
// execute and write, then a second read for the reported entry
// in a tick, the neighbour sweep reads one route entry per cycle
// and writes the entry read in the previous cycle through the single write port
// reset clears all flags and valid bits at once; no clearing pass
// a request is accepted while the previous result still waits in the output register
// a result stall holds only the final step, never the sweep
module distance_vector_route_table_unit #(
    parameter int NODES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  dvrt_pkg::dvrt_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output dvrt_pkg::dvrt_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);

    dvrt_pkg::dvrt_cmd_t  cmd;
    dvrt_pkg::dvrt_stat_t stat;

    assign cfg_ready = 1'b1;

    dvrt_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    dvrt_datapath #(
        .NODES (NODES)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// File: dv/dvrt_route_checker.sv
// dvrt_route_checker: keeps its own copy of the distance-vector table and checks every result
// watches the request, result and node-id channels; depends on dvrt_pkg
// hands failure, match and outstanding counts to the testbench top
module dvrt_route_checker #(
    parameter int NODES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  dvrt_pkg::dvrt_in_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  dvrt_pkg::dvrt_out_t result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [4:0]          cfg_data,
    output int                  fail_count,
    output int                  matched,
    output int                  outstanding
);

    logic [4:0]  node_id;
    logic [15:0] route_cost [NODES];
    logic [4:0]  next_hop [NODES];
    logic        is_neighbour [NODES];
    logic [15:0] link_cost [NODES];
    logic [1:0]  missed [NODES];
    logic        heard [NODES];

    dvrt_pkg::dvrt_out_t expected_reports [$];

    function automatic logic valid_id(logic [4:0] id);
        return id >= 5'd1 && int'(id) <= NODES;
    endfunction

    function automatic logic own_id(logic [4:0] id);
        return valid_id(id) && id == node_id;
    endfunction

    function automatic dvrt_pkg::dvrt_out_t entry_report(logic [4:0] id);
        dvrt_pkg::dvrt_out_t rsp;
        rsp = '0;
        if (!valid_id(id))
            rsp.entry_cost = dvrt_pkg::INF_COST;
        else
        begin
            rsp.entry_id = id;
            if (!own_id(id))
            begin
                rsp.entry_cost        = route_cost[int'(id) - 1];
                rsp.entry_next_hop    = next_hop[int'(id) - 1];
                rsp.entry_is_neighbor = is_neighbour[int'(id) - 1];
            end
        end
        return rsp;
    endfunction

    function automatic logic set_route(int idx, logic [15:0] cost, logic [4:0] hop);
        logic moved;
        moved           = (route_cost[idx] != cost) || (next_hop[idx] != hop);
        route_cost[idx] = cost;
        next_hop[idx]   = hop;
        return moved;
    endfunction

    task automatic predict_request(input dvrt_pkg::dvrt_in_t req,
                                   output dvrt_pkg::dvrt_out_t rsp);
        logic        changed;
        logic        peer_ok;
        int          p;
        int          d;
        int          i;
        logic [16:0] via_cost;
        changed = 1'b0;
        peer_ok = valid_id(req.peer_id) && !own_id(req.peer_id);
        p       = peer_ok ? int'(req.peer_id) - 1 : 0;
        rsp     = '0;
        case (req.mode)
            dvrt_pkg::MODE_VECTOR:
            begin
                if (peer_ok && is_neighbour[p])
                begin
                    heard[p]  = 1'b1;
                    missed[p] = '0;
                    if (valid_id(req.dest_id) && !own_id(req.dest_id))
                    begin
                        d        = int'(req.dest_id) - 1;
                        via_cost = link_cost[p] + req.cost_value;
                        if (via_cost > {1'b0, dvrt_pkg::INF_COST})
                            via_cost = {1'b0, dvrt_pkg::INF_COST};
                        if (via_cost[15:0] < route_cost[d])
                            changed = set_route(d, via_cost[15:0], req.peer_id);
                    end
                end
                rsp = entry_report(req.dest_id);
            end
            dvrt_pkg::MODE_TICK:
            begin
                for (i = 0; i < NODES; i++)
                begin
                    if (is_neighbour[i] && heard[i])
                    begin
                        if (missed[i] < dvrt_pkg::MISS_LIMIT)
                            missed[i] = missed[i] + 2'd1;
                        if (missed[i] >= dvrt_pkg::MISS_LIMIT && !own_id(5'(i + 1)))
                        begin
                            if (route_cost[i] != dvrt_pkg::INF_COST)
                                changed = 1'b1;
                            route_cost[i] = dvrt_pkg::INF_COST;
                        end
                    end
                end
                rsp.send_update = 1'b1;
            end
            dvrt_pkg::MODE_DISABLE:
            begin
                if (peer_ok && is_neighbour[p])
                begin
                    changed         = set_route(p, dvrt_pkg::INF_COST, 5'd0);
                    is_neighbour[p] = 1'b0;
                    heard[p]        = 1'b0;
                    missed[p]       = '0;
                end
                rsp = entry_report(req.peer_id);
            end
            dvrt_pkg::MODE_SET_COST:
            begin
                if (peer_ok && is_neighbour[p])
                begin
                    link_cost[p] = req.cost_value;
                    changed      = set_route(p, req.cost_value, req.peer_id);
                end
                rsp = entry_report(req.peer_id);
            end
            dvrt_pkg::MODE_READ:
                rsp = entry_report(req.dest_id);
            dvrt_pkg::MODE_LOAD:
            begin
                if (peer_ok)
                begin
                    is_neighbour[p] = 1'b1;
                    link_cost[p]    = req.cost_value;
                    missed[p]       = '0;
                    heard[p]        = 1'b0;
                    changed         = set_route(p, req.cost_value, req.peer_id);
                end
                rsp = entry_report(req.peer_id);
            end
            default:
                rsp = '0;
        endcase
        rsp.table_changed = changed;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s expected %0d got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dvrt_pkg::dvrt_out_t want;
        int                  i;
        if (!rst_n)
        begin
            node_id = dvrt_pkg::SELF_RESET;
            for (i = 0; i < NODES; i++)
            begin
                route_cost[i]   = dvrt_pkg::INF_COST;
                next_hop[i]     = '0;
                is_neighbour[i] = 1'b0;
                link_cost[i]    = dvrt_pkg::INF_COST;
                missed[i]       = '0;
                heard[i]        = 1'b0;
            end
            expected_reports.delete();
            fail_count  = 0;
            matched     = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result %h with no request outstanding", result);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("entry_id", 16'(want.entry_id), 16'(result.entry_id));
                    compare_field("entry_cost", want.entry_cost, result.entry_cost);
                    compare_field("entry_next_hop", 16'(want.entry_next_hop),
                                  16'(result.entry_next_hop));
                    compare_field("entry_is_neighbor", 16'(want.entry_is_neighbor),
                                  16'(result.entry_is_neighbor));
                    compare_field("table_changed", 16'(want.table_changed),
                                  16'(result.table_changed));
                    compare_field("send_update", 16'(want.send_update),
                                  16'(result.send_update));
                    matched++;
                end
            end
            if (cfg_valid && cfg_ready)
                node_id = cfg_data;
            if (item_valid && item_ready)
            begin
                predict_request(item, want);
                expected_reports.push_back(want);
            end
            outstanding <= expected_reports.size();
        end
    end

endmodule

// File: dv/tb_distance_vector_route_table_unit.sv
// tb_distance_vector_route_table_unit: drives the route table with directed and random requests
// and node-id changes, bursty on the request side and stalling on the result side
// depends on dvrt_pkg, distance_vector_route_table_unit and dvrt_route_checker
module tb_distance_vector_route_table_unit;

    localparam int NODES     = 16;
    localparam int PHASE_LEN = 166;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef enum logic [1:0] {ALWAYS_READY, COIN_FLIP, SPARSE, SQUARE_WAVE} stall_style_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    dvrt_pkg::dvrt_in_t  item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    dvrt_pkg::dvrt_out_t result;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [4:0]          cfg_data     = '0;

    int           fail_count;
    int           matched;
    int           outstanding;
    int           issued      = 0;
    int           tick_count  = 0;
    int           settings    = 0;
    logic [5:0]   stall_phase;
    stall_style_t stall_style;

    distance_vector_route_table_unit #(
        .NODES(NODES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    dvrt_route_checker #(
        .NODES(NODES)
    ) route_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .matched      (matched),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // result side stalls on its own pattern, restyled each time the phase counter wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_phase  <= '0;
            stall_style  <= ALWAYS_READY;
        end
        else
        begin
            stall_phase <= stall_phase + 6'd1;
            if (stall_phase == '0)
                stall_style <= stall_style_t'($urandom_range(0, 3));
            case (stall_style)
                ALWAYS_READY: result_ready <= 1'b1;
                COIN_FLIP:    result_ready <= 1'($urandom_range(0, 1));
                SPARSE:       result_ready <= ($urandom_range(0, 5) == 0);
                default:      result_ready <= stall_phase[3];
            endcase
        end
    end

    function automatic logic [4:0] random_id();
        if ($urandom_range(0, 99) < 94)
            return 5'($urandom_range(1, NODES));
        else if ($urandom_range(0, 1) == 0)
            return 5'd0;
        else
            return 5'($urandom_range(NODES + 1, 31));
    endfunction

    function automatic dvrt_pkg::dvrt_in_t random_request();
        dvrt_pkg::dvrt_in_t req;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            req.mode = dvrt_pkg::MODE_VECTOR;
        else if (pick < 48)
            req.mode = dvrt_pkg::MODE_TICK;
        else if (pick < 53)
            req.mode = dvrt_pkg::MODE_DISABLE;
        else if (pick < 62)
            req.mode = dvrt_pkg::MODE_SET_COST;
        else if (pick < 78)
            req.mode = dvrt_pkg::MODE_READ;
        else if (pick < 93)
            req.mode = dvrt_pkg::MODE_LOAD;
        else
            req.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
        req.peer_id = random_id();
        req.dest_id = random_id();
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req.cost_value = 16'($urandom_range(0, 40));
        else if (pick < 50)
            req.cost_value = dvrt_pkg::INF_COST;
        else if (pick < 62)
            req.cost_value = 16'($urandom_range(65400, 65535));
        else if (pick < 70)
            req.cost_value = '0;
        else
            req.cost_value = 16'($urandom_range(0, 65535));
        return req;
    endfunction

    // leaves valid high; the caller lowers it for a gap
    task automatic send_request(input dvrt_pkg::dvrt_in_t req);
        item       <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        issued++;
        if (req.mode == dvrt_pkg::MODE_TICK)
            tick_count++;
    endtask

    task automatic issue(input logic [2:0] mode, input logic [4:0] peer,
                         input logic [4:0] dest, input logic [15:0] cost);
        dvrt_pkg::dvrt_in_t req;
        req.mode       = mode;
        req.peer_id    = peer;
        req.dest_id    = dest;
        req.cost_value = cost;
        send_request(req);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (NODES + 8) @(posedge clk);
    endtask

    task automatic write_node_id(input logic [4:0] id);
        cfg_data  <= id;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input logic [4:0] id, input int count);
        int sent;
        int burst;
        int k;
        write_node_id(id);
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_request(random_request());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin : stimulus
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // node id still at its reset value here
        issue(dvrt_pkg::MODE_READ, 5'd0, 5'd1, 16'd0);
        issue(dvrt_pkg::MODE_LOAD, 5'd2, 5'd0, 16'd10);
        issue(dvrt_pkg::MODE_LOAD, 5'd1, 5'd0, 16'd5);
        issue(dvrt_pkg::MODE_LOAD, 5'd16, 5'd0, 16'd0);
        issue(dvrt_pkg::MODE_LOAD, 5'd4, 5'd0, 16'd65000);
        issue(dvrt_pkg::MODE_VECTOR, 5'd2, 5'd5, 16'd7);
        issue(dvrt_pkg::MODE_VECTOR, 5'd2, 5'd5, 16'd20);
        issue(dvrt_pkg::MODE_VECTOR, 5'd3, 5'd6, 16'd1);
        issue(dvrt_pkg::MODE_VECTOR, 5'd2, 5'd1, 16'd0);
        issue(dvrt_pkg::MODE_VECTOR, 5'd16, 5'd7, dvrt_pkg::INF_COST);
        issue(dvrt_pkg::MODE_VECTOR, 5'd4, 5'd8, 16'd1000);
        issue(dvrt_pkg::MODE_VECTOR, 5'd4, 5'd8, 16'd534);
        issue(dvrt_pkg::MODE_VECTOR, 5'd1, 5'd9, 16'd3);
        issue(dvrt_pkg::MODE_SET_COST, 5'd2, 5'd0, 16'd3);
        issue(dvrt_pkg::MODE_SET_COST, 5'd9, 5'd0, 16'd3);
        issue(dvrt_pkg::MODE_LOAD, 5'd12, 5'd0, 16'd20);
        repeat (3) issue(dvrt_pkg::MODE_TICK, 5'd0, 5'd0, 16'd0);
        issue(dvrt_pkg::MODE_DISABLE, 5'd4, 5'd0, 16'd0);
        issue(dvrt_pkg::MODE_DISABLE, 5'd5, 5'd0, 16'd0);
        issue(dvrt_pkg::MODE_READ, 5'd0, 5'd0, 16'd0);
        issue(dvrt_pkg::MODE_VECTOR, 5'd0, 5'd31, dvrt_pkg::INF_COST);
        issue(MODE_SPARE_A, 5'd31, 5'd31, dvrt_pkg::INF_COST);
        drain();

        // 22 lies outside the table, so no entry is this node's own
        run_phase(5'd16, PHASE_LEN);
        run_phase(5'd7, PHASE_LEN);
        run_phase(5'd22, PHASE_LEN);
        run_phase(5'd10, PHASE_LEN);
        run_phase(5'd1, PHASE_LEN);

        $display("covered %0d requests (%0d ticks) over %0d node-id settings plus reset,",
                 issued, tick_count, settings);
        $display("with %0d results compared against the table model", matched);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
